// File: src/mws_pkg.sv
// Shared types and constants for the majority window smoothing block.
package mws_pkg;

    // Width of a tile code on the ports and inside the datapath.
    localparam int TILE_BITS = 16;
    localparam int CODE_BITS = 16;

    // Default line buffer depth (maximum grid width).
    localparam int MAX_WIDTH_DEF = 1024;

    // Depth of the result queue in front of the output channel.
    localparam int OUT_DEPTH = 4;

    // Configuration port geometry.
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // Register reset values.
    localparam logic [15:0] WATER_RST  = 16'd4608;
    localparam logic [15:0] GROUND_RST = 16'd4526;
    localparam logic [10:0] WIDTH_RST  = 11'd1024;
    localparam logic [15:0] HEIGHT_RST = 16'd1024;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_WATER  = 2'd0,
        REG_GROUND = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg_idx;

    typedef logic [CODE_BITS-1:0] t_code;

    // One line buffer word: the two rows above the incoming cell.
    typedef struct packed {
        t_code upper;
        t_code lower;
    } t_pair;

    // Control and data of the item in the memory read stage.
    typedef struct packed {
        logic  shift;
        logic  emit;
        logic  border;
        logic  last;
        logic  fwd;
        t_code value;
    } t_stage_b;

    // One result beat.
    typedef struct packed {
        logic [TILE_BITS-1:0] tile;
        logic                 changed;
        logic                 frame_end;
    } t_result;

endpackage

// File: src/mws_line_mem.sv
// Two-row line buffer memory with a registered read port.
module mws_line_mem #(
    parameter int MAX_WIDTH = mws_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  mws_pkg::t_pair               i_wr_data,
    output mws_pkg::t_pair               o_rd_data
);

    mws_pkg::t_pair r_mem [MAX_WIDTH];
    mws_pkg::t_pair r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered; a same-address write is not seen.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/mws_window.sv
// 3x3 window registers, line buffer forwarding and the majority decision.
module mws_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mws_pkg::t_stage_b  i_b,
    input  mws_pkg::t_pair     i_rd,
    input  mws_pkg::t_code     i_water,
    input  mws_pkg::t_code     i_ground,
    output mws_pkg::t_pair     o_wr,
    output logic               o_res_valid,
    output mws_pkg::t_result   o_res
);

    mws_pkg::t_code r_win [9];
    mws_pkg::t_pair r_fwd;
    logic           r_c_valid;
    logic           r_c_border;
    logic           r_c_last;

    mws_pkg::t_code eff_upper;
    mws_pkg::t_code eff_lower;
    mws_pkg::t_code colv [3];
    logic [3:0]     wet;
    logic [3:0]     dry;
    mws_pkg::t_code center;
    mws_pkg::t_code result;

    // The previous item writes the same column as this one is read: take its data.
    always_comb begin
        eff_upper = i_b.fwd ? r_fwd.upper : i_rd.upper;
        eff_lower = i_b.fwd ? r_fwd.lower : i_rd.lower;
        colv[0]   = eff_upper;
        colv[1]   = eff_lower;
        colv[2]   = i_b.value;
    end

    // The column moves up one row in the line buffer.
    assign o_wr.upper = eff_lower;
    assign o_wr.lower = i_b.value;

    // Window shift and forwarding copy.
    always_ff @(posedge i_clk) begin
        if (i_b.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3+1];
                r_win[r*3+1]   <= r_win[r*3+2];
                r_win[r*3+2]   <= colv[r];
            end
            r_fwd.upper <= eff_lower;
            r_fwd.lower <= i_b.value;
        end
    end

    // Decision stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_b.shift & i_b.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_border <= i_b.border;
        r_c_last   <= i_b.last;
    end

    // Count water and land among the eight neighbors and pick the result.
    always_comb begin
        wet    = '0;
        dry    = '0;
        center = r_win[4];
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                if (r_win[i] == i_water) begin
                    wet = wet + 4'd1;
                end else if (r_win[i] == i_ground) begin
                    dry = dry + 4'd1;
                end
            end
        end
        result = center;
        if (!r_c_border) begin
            if (center == i_water && dry > wet) begin
                result = i_ground;
            end else if (center == i_ground && wet > dry) begin
                result = i_water;
            end
        end
    end

    assign o_res_valid     = r_c_valid;
    assign o_res.tile      = mws_pkg::TILE_BITS'(result);
    assign o_res.changed   = (result != center);
    assign o_res.frame_end = r_c_last;

endmodule

// File: src/mws_out_fifo.sv
// Small result queue that decouples the output channel from the pipeline.
module mws_out_fifo (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_push,
    input  mws_pkg::t_result                         i_data,
    input  logic                                     i_pop,
    output logic                                     o_valid,
    output mws_pkg::t_result                         o_data,
    output logic [$clog2(mws_pkg::OUT_DEPTH+1)-1:0]  o_count
);

    localparam int PW = $clog2(mws_pkg::OUT_DEPTH);
    localparam int CW = $clog2(mws_pkg::OUT_DEPTH + 1);

    mws_pkg::t_result r_buf [mws_pkg::OUT_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(mws_pkg::OUT_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(mws_pkg::OUT_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: src/majority_window_smoothing.sv
// Top level of the 3x3 majority smoothing block: configuration, positions and pipeline.
//
// Usage: tile codes enter in raster order on the input channel (i_in_valid,
// o_in_stall, i_tile_in, i_drain); each beat carries one cell. Results leave
// in raster order on the output channel (o_out_valid, i_out_stall) with the
// smoothed code, a changed flag and a frame end flag on the last cell.
// Results trail the input by one row plus one cell; after the last cell of
// a frame the source sends width plus one drain beats to flush the rest.
// A drain beat while cells of the frame are still missing gives nothing.
// Throughput is one beat per cycle while input is not stalled: the line
// buffer memory is read when a beat is accepted and written back the cycle
// after, with forwarding when consecutive beats hit the same column. A result
// passes the read stage, the decision stage and the queue on its way out.
// When the receiver stalls, results collect in a four-entry queue; input is
// stalled only once the queue and the results in flight would fill it.
// Reset clears positions, the pipeline and the queue and loads the register
// defaults; unwritten line buffer data reaches only border results, which
// keep their center. The user writes registers only while idle; the block
// does not enforce it. A write of the grid width or height restarts the frame.
module majority_window_smoothing #(
    parameter int MAX_WIDTH = mws_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mws_pkg::TILE_BITS-1:0]  i_tile_in,
    input  logic                           i_drain,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mws_pkg::TILE_BITS-1:0]  o_tile_out,
    output logic                           o_changed,
    output logic                           o_frame_end,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mws_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mws_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mws_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int QCW = $clog2(mws_pkg::OUT_DEPTH + 1);

    // Configuration registers
    logic [15:0] r_water;
    logic [15:0] r_ground;
    logic [10:0] r_grid_width;
    logic [15:0] r_grid_height;

    // Positions
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [15:0]   r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [15:0]   r_out_row, n_out_row;

    // Memory read stage
    mws_pkg::t_stage_b r_b, n_b;
    logic [CW-1:0]     r_b_col;

    logic              cfg_wr;
    mws_pkg::t_reg_idx cfg_idx;
    logic              accept;
    logic [WW-1:0]     w_eff;
    logic [15:0]       h_eff;
    logic              data_phase;
    logic              ready;
    logic [WW-1:0]     in_col_inc;
    logic [WW-1:0]     out_col_inc;
    logic [CW-1:0]     a_col;
    logic              out_last;
    logic              out_border;

    mws_pkg::t_pair    rd_pair;
    mws_pkg::t_pair    wr_pair;
    logic              res_valid;
    mws_pkg::t_result  res;
    mws_pkg::t_result  q_data;
    logic              q_valid;
    logic [QCW-1:0]    q_count;
    logic [QCW:0]      pending;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_idx = mws_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water       <= mws_pkg::WATER_RST;
            r_ground      <= mws_pkg::GROUND_RST;
            r_grid_width  <= mws_pkg::WIDTH_RST;
            r_grid_height <= mws_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mws_pkg::REG_WATER:  r_water       <= pwdata[15:0];
                mws_pkg::REG_GROUND: r_ground      <= pwdata[15:0];
                mws_pkg::REG_WIDTH:  r_grid_width  <= pwdata[10:0];
                mws_pkg::REG_HEIGHT: r_grid_height <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mws_pkg::REG_WATER:  prdata = mws_pkg::DATA_BITS'(r_water);
            mws_pkg::REG_GROUND: prdata = mws_pkg::DATA_BITS'(r_ground);
            mws_pkg::REG_WIDTH:  prdata = mws_pkg::DATA_BITS'(r_grid_width);
            mws_pkg::REG_HEIGHT: prdata = mws_pkg::DATA_BITS'(r_grid_height);
        endcase
    end

    // Effective geometry, saturated to the supported range.
    always_comb begin
        if (r_grid_width < 11'd3) begin
            w_eff = WW'(3);
        end else if (int'(r_grid_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_grid_width);
        end
        h_eff = (r_grid_height < 16'd3) ? 16'd3 : r_grid_height;
    end

    // Input stalls once the queue could not take every result in flight.
    assign pending    = (QCW+1)'(q_count) + (QCW+1)'(r_b.shift & r_b.emit) +
                        (QCW+1)'(res_valid);
    assign o_in_stall = (pending >= (QCW+1)'(mws_pkg::OUT_DEPTH));
    assign accept     = i_in_valid & ~o_in_stall;

    // Accept stage: decide shift, column and emit for the beat.
    always_comb begin
        data_phase  = (r_in_row < h_eff);
        ready       = (r_in_row >= 16'd2) || (r_in_row >= 16'd1 && r_in_col != '0);
        in_col_inc  = WW'(r_in_col) + WW'(1);
        out_col_inc = WW'(r_out_col) + WW'(1);
        a_col       = data_phase ? r_in_col :
                      ((out_col_inc >= w_eff) ? '0 : CW'(out_col_inc));
        out_last    = (r_out_row == h_eff - 16'd1) && (WW'(r_out_col) == w_eff - WW'(1));
        out_border  = (r_out_row == '0) || (r_out_row >= h_eff - 16'd1) ||
                      (r_out_col == '0) || (WW'(r_out_col) >= w_eff - WW'(1));

        n_b.shift   = accept & ~(data_phase & i_drain);
        n_b.emit    = data_phase ? (~i_drain & ready) : 1'b1;
        n_b.border  = out_border;
        n_b.last    = out_last;
        n_b.fwd     = r_b.shift && (a_col == r_b_col);
        n_b.value   = data_phase ? mws_pkg::CODE_BITS'(i_tile_in) : '0;
    end

    // Position counters.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_wr && (cfg_idx == mws_pkg::REG_WIDTH || cfg_idx == mws_pkg::REG_HEIGHT)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (n_b.shift) begin
            if (data_phase) begin
                if (in_col_inc >= w_eff) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 16'd1;
                end else begin
                    n_in_col = CW'(in_col_inc);
                end
            end
            if (n_b.emit) begin
                if (out_last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_inc >= w_eff) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 16'd1;
                end else begin
                    n_out_col = CW'(out_col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_b       <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_b       <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_col <= a_col;
    end

    // Line buffer: read at accept, written back from the read stage.
    mws_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_addr (a_col),
        .i_wr_en   (r_b.shift),
        .i_wr_addr (r_b_col),
        .i_wr_data (wr_pair),
        .o_rd_data (rd_pair)
    );

    // Window and decision.
    mws_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_b         (r_b),
        .i_rd        (rd_pair),
        .i_water     (mws_pkg::CODE_BITS'(r_water)),
        .i_ground    (mws_pkg::CODE_BITS'(r_ground)),
        .o_wr        (wr_pair),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result queue.
    mws_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (q_valid & ~i_out_stall),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_out_valid = q_valid;
    assign o_tile_out  = q_data.tile;
    assign o_changed   = q_data.changed;
    assign o_frame_end = q_data.frame_end;

endmodule
